>>> sv/spinor_bracket_product_defines.svh
// ----------------------------------------------------------------------------
// spinor_bracket_product_defines
// Assertion macros of the spinor bracket product RTL.
// ----------------------------------------------------------------------------
`ifndef SPINOR_BRACKET_PRODUCT_DEFINES_SVH
`define SPINOR_BRACKET_PRODUCT_DEFINES_SVH

// checked outside reset
`define SBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define SBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

>>> sv/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg
// Types and constants of the spinor bracket product pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int OUT_W         = 48;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ETA_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_SECOND = 1'd1;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] first_energy;
        logic signed [DATA_W-1:0] first_px;
        logic signed [DATA_W-1:0] first_py;
        logic signed [DATA_W-1:0] first_pz;
        logic                     first_off_shell;
        logic signed [DATA_W-1:0] second_energy;
        logic signed [DATA_W-1:0] second_px;
        logic signed [DATA_W-1:0] second_py;
        logic signed [DATA_W-1:0] second_pz;
        logic                     second_off_shell;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] product_re;
        logic signed [OUT_W-1:0] product_im;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] energy;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic                     off_shell;
    } t_momentum;

    typedef struct packed {
        logic signed [DATA_W-1:0] eta_first;
        logic signed [DATA_W-1:0] eta_second;
    } t_eta;

    typedef struct packed {
        logic en;
        logic valid;
        logic conj;
    } t_spin_ctl;

    typedef struct packed {
        logic signed [DATA_W-1:0] l0_re;
        logic signed [DATA_W-1:0] l0_im;
        logic signed [DATA_W-1:0] l1_re;
        logic signed [DATA_W-1:0] l1_im;
    } t_spinor;

endpackage

`default_nettype wire

>>> sv/sbp_in_if.sv
// ----------------------------------------------------------------------------
// sbp_in_if
// Valid/ready channel carrying one momentum pair per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbp_in_if;
    import sbp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sbp_out_if.sv
// ----------------------------------------------------------------------------
// sbp_out_if
// Valid/ready channel carrying one bracket product per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbp_out_if;
    import sbp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sbp_spinor.sv
// ----------------------------------------------------------------------------
// sbp_spinor
// Pipelined spinor of one four-momentum: bit-per-stage square root,
// bit-per-stage dividers, then reference projection and selection.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_spinor #(
    parameter int FRAC_BITS = sbp_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbp_pkg::t_spin_ctl i_ctl,
    input  sbp_pkg::t_momentum i_mom,
    input  sbp_pkg::t_eta     i_eta,
    output logic              o_valid,
    output sbp_pkg::t_spinor  o_spinor,
    output logic              o_clip
);
    import sbp_pkg::*;

    localparam int SUM_W = DATA_W + 1;
    localparam int NW    = SUM_W + FRAC_BITS;
    localparam int NE    = NW + (NW % 2);
    localparam int RW    = NE / 2;
    localparam int DW    = DATA_W + FRAC_BITS;
    localparam int PW    = SUM_W + DATA_W;
    localparam int AW    = PW + 1;

    localparam logic [DATA_W-1:0] POS_RAIL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_RAIL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [AW-1:0] SP_MAX = AW'(POS_RAIL);
    localparam logic signed [AW-1:0] SP_MIN = AW'($signed(NEG_RAIL));

    typedef struct packed {
        logic [SUM_W-1:0]  s;
        logic [SUM_W-1:0]  d;
        logic [DATA_W-1:0] px;
        logic [SUM_W-1:0]  y;
        logic              off;
        logic              zs;
        logic              neg;
    } t_carry;

    function automatic logic [DATA_W:0] f_sat(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] v;
        v = a >>> FRAC_BITS;
        if (v > SP_MAX) return {1'b1, POS_RAIL};
        if (v < SP_MIN) return {1'b1, NEG_RAIL};
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    function automatic logic [DATA_W:0] f_qsat(input logic [DW-1:0] q, input logic sgn);
        if (sgn) begin
            if (q > DW'(NEG_RAIL)) return {1'b1, NEG_RAIL};
            return {1'b0, DATA_W'(~q + 1'b1)};
        end
        if (q > DW'(POS_RAIL)) return {1'b1, POS_RAIL};
        return {1'b0, q[DATA_W-1:0]};
    endfunction

    // square root stages
    logic            r_sv   [RW+1];
    t_carry          r_sc   [RW+1];
    logic [RW-1:0]   r_root [RW+1];
    logic [RW+1:0]   r_rem  [RW];
    logic [NE-1:0]   r_n    [RW];
    logic            n_sv   [RW+1];
    t_carry          n_sc   [RW+1];
    logic [RW-1:0]   n_root [RW+1];
    logic [RW+1:0]   n_rem  [RW];
    logic [NE-1:0]   n_n    [RW];
    logic [RW+1:0]   w_remx [RW];
    logic            w_sge  [RW];

    // divider stages
    logic            r_dv   [DW+1];
    t_carry          r_dc   [DW+1];
    logic [RW-1:0]   r_dr   [DW+1];
    logic [DW-1:0]   r_qa   [DW+1];
    logic [DW-1:0]   r_qb   [DW+1];
    logic [RW-1:0]   r_ra   [DW];
    logic [RW-1:0]   r_rb   [DW];
    logic            n_dv   [DW+1];
    t_carry          n_dc   [DW+1];
    logic [RW-1:0]   n_dr   [DW+1];
    logic [DW-1:0]   n_qa   [DW+1];
    logic [DW-1:0]   n_qb   [DW+1];
    logic [RW-1:0]   n_ra   [DW];
    logic [RW-1:0]   n_rb   [DW];
    logic [RW:0]     w_rxa  [DW];
    logic [RW:0]     w_rxb  [DW];
    logic            w_gea  [DW];
    logic            w_geb  [DW];

    // projection and selection stages
    logic                   r_mv;
    logic                   r_moff;
    logic                   r_mzs;
    logic                   r_mneg;
    logic [RW-1:0]          r_mroot;
    logic signed [PW-1:0]   r_mp [6];
    logic [DATA_W:0]        r_mqa;
    logic [DATA_W:0]        r_mqb;
    logic signed [PW-1:0]   n_mp [6];
    logic [DATA_W:0]        n_mqa;
    logic [DATA_W:0]        n_mqb;
    logic                   r_ov;
    t_spinor                r_osp;
    logic                   r_oclip;
    t_spinor                n_osp;
    logic                   n_oclip;

    logic [SUM_W-1:0] w_e;
    logic [SUM_W-1:0] w_pz;
    logic [SUM_W-1:0] w_py;
    logic [SUM_W-1:0] w_s;
    logic [SUM_W-1:0] w_d;
    logic [SUM_W-1:0] w_u;
    logic             w_zs;
    logic [SUM_W-1:0] w_pxe;
    logic [SUM_W-1:0] w_npx;
    logic [SUM_W-1:0] w_xa;
    logic [SUM_W-1:0] w_xb;
    logic [SUM_W-1:0] w_ma;
    logic [SUM_W-1:0] w_mb;
    logic [SUM_W-1:0] w_mpxe;
    logic [SUM_W-1:0] w_mnpx;
    logic [SUM_W-1:0] w_mny;
    logic             w_sga;
    logic             w_sgb;
    logic [DATA_W:0]  w_o0r;
    logic [DATA_W:0]  w_o0i;
    logic [DATA_W:0]  w_o1r;
    logic [DATA_W:0]  w_o1i;
    logic [DATA_W-1:0] w_rootx;

    // entry: sums, root operand
    always_comb begin
        w_e  = SUM_W'(i_mom.energy);
        w_pz = SUM_W'(i_mom.pz);
        w_py = SUM_W'(i_mom.py);
        w_s  = w_e + w_pz;
        w_d  = w_e - w_pz;
        w_zs = (w_s == '0);
        if (w_zs) begin
            w_u = w_d[SUM_W-1] ? SUM_W'(0) - w_d : w_d;
        end else begin
            w_u = w_s[SUM_W-1] ? SUM_W'(0) - w_s : w_s;
        end
        n_sv[0]      = i_ctl.valid;
        n_sc[0].s    = w_s;
        n_sc[0].d    = w_d;
        n_sc[0].px   = i_mom.px;
        n_sc[0].y    = i_ctl.conj ? SUM_W'(0) - w_py : w_py;
        n_sc[0].off  = i_mom.off_shell;
        n_sc[0].zs   = w_zs;
        n_sc[0].neg  = w_zs ? w_d[SUM_W-1] : w_s[SUM_W-1];
        n_root[0]    = '0;
        n_rem[0]     = '0;
        n_n[0]       = NE'({w_u, {FRAC_BITS{1'b0}}});
    end

    // square root, one result bit per stage
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            w_remx[k]   = {r_rem[k][RW-1:0], r_n[k][NE-1 -: 2]};
            w_sge[k]    = (w_remx[k] >= {r_root[k], 2'b01});
            n_sv[k+1]   = r_sv[k];
            n_sc[k+1]   = r_sc[k];
            n_root[k+1] = {r_root[k][RW-2:0], w_sge[k]};
        end
        for (int k = 0; k < RW - 1; k++) begin
            n_rem[k+1] = w_sge[k] ? w_remx[k] - {r_root[k], 2'b01} : w_remx[k];
            n_n[k+1]   = {r_n[k][NE-3:0], 2'b00};
        end
    end

    // divider entry: numerator magnitudes
    always_comb begin
        w_pxe = SUM_W'($signed(r_sc[RW].px));
        w_npx = SUM_W'(0) - w_pxe;
        w_xa  = r_sc[RW].neg ? r_sc[RW].y : w_pxe;
        w_xb  = r_sc[RW].neg ? w_npx : r_sc[RW].y;
        w_ma  = w_xa[SUM_W-1] ? SUM_W'(0) - w_xa : w_xa;
        w_mb  = w_xb[SUM_W-1] ? SUM_W'(0) - w_xb : w_xb;
        n_dv[0] = r_sv[RW];
        n_dc[0] = r_sc[RW];
        n_dr[0] = r_root[RW];
        n_qa[0] = {w_ma[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        n_qb[0] = {w_mb[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        n_ra[0] = '0;
        n_rb[0] = '0;
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < DW; j++) begin
            w_rxa[j]  = {r_ra[j], r_qa[j][DW-1]};
            w_rxb[j]  = {r_rb[j], r_qb[j][DW-1]};
            w_gea[j]  = (w_rxa[j] >= {1'b0, r_dr[j]});
            w_geb[j]  = (w_rxb[j] >= {1'b0, r_dr[j]});
            n_dv[j+1] = r_dv[j];
            n_dc[j+1] = r_dc[j];
            n_dr[j+1] = r_dr[j];
            n_qa[j+1] = {r_qa[j][DW-2:0], w_gea[j]};
            n_qb[j+1] = {r_qb[j][DW-2:0], w_geb[j]};
        end
        for (int j = 0; j < DW - 1; j++) begin
            n_ra[j+1] = w_gea[j] ? RW'(w_rxa[j] - {1'b0, r_dr[j]}) : w_rxa[j][RW-1:0];
            n_rb[j+1] = w_geb[j] ? RW'(w_rxb[j] - {1'b0, r_dr[j]}) : w_rxb[j][RW-1:0];
        end
    end

    // reference projection products, quotient saturation
    always_comb begin
        w_mpxe = SUM_W'($signed(r_dc[DW].px));
        w_mnpx = SUM_W'(0) - w_mpxe;
        w_mny  = SUM_W'(0) - r_dc[DW].y;
        w_sga  = r_dc[DW].neg ? r_dc[DW].y[SUM_W-1] : w_mpxe[SUM_W-1];
        w_sgb  = r_dc[DW].neg ? w_mnpx[SUM_W-1] : r_dc[DW].y[SUM_W-1];
        n_mqa  = f_qsat(r_qa[DW], w_sga);
        n_mqb  = f_qsat(r_qb[DW], w_sgb);
        n_mp[0] = PW'($signed(r_dc[DW].s)) * PW'(i_eta.eta_first);
        n_mp[1] = PW'($signed(w_mpxe)) * PW'(i_eta.eta_second);
        n_mp[2] = PW'($signed(w_mny)) * PW'(i_eta.eta_second);
        n_mp[3] = PW'($signed(w_mpxe)) * PW'(i_eta.eta_first);
        n_mp[4] = PW'($signed(r_dc[DW].d)) * PW'(i_eta.eta_second);
        n_mp[5] = PW'($signed(r_dc[DW].y)) * PW'(i_eta.eta_first);
    end

    // select the spinor form
    always_comb begin
        w_o0r   = f_sat(AW'(r_mp[0]) + AW'(r_mp[1]));
        w_o0i   = f_sat(AW'(r_mp[2]));
        w_o1r   = f_sat(AW'(r_mp[3]) + AW'(r_mp[4]));
        w_o1i   = f_sat(AW'(r_mp[5]));
        w_rootx = DATA_W'(r_mroot);
        n_osp   = '0;
        n_oclip = 1'b0;
        if (r_moff) begin
            n_osp.l0_re = w_o0r[DATA_W-1:0];
            n_osp.l0_im = w_o0i[DATA_W-1:0];
            n_osp.l1_re = w_o1r[DATA_W-1:0];
            n_osp.l1_im = w_o1i[DATA_W-1:0];
            n_oclip = w_o0r[DATA_W] | w_o0i[DATA_W] | w_o1r[DATA_W] | w_o1i[DATA_W];
        end else if (!r_mzs) begin
            n_osp.l0_re = r_mneg ? '0 : w_rootx;
            n_osp.l0_im = r_mneg ? w_rootx : '0;
            n_osp.l1_re = r_mqa[DATA_W-1:0];
            n_osp.l1_im = r_mqb[DATA_W-1:0];
            n_oclip = r_mqa[DATA_W] | r_mqb[DATA_W];
        end else begin
            n_osp.l1_re = r_mneg ? '0 : w_rootx;
            n_osp.l1_im = r_mneg ? w_rootx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RW; k++) r_sv[k] <= 1'b0;
            for (int j = 0; j <= DW; j++) r_dv[j] <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ctl.en) begin
            for (int k = 0; k <= RW; k++) r_sv[k] <= n_sv[k];
            for (int j = 0; j <= DW; j++) r_dv[j] <= n_dv[j];
            r_mv <= r_dv[DW];
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k <= RW; k++) begin
                r_sc[k]   <= n_sc[k];
                r_root[k] <= n_root[k];
            end
            for (int k = 0; k < RW; k++) begin
                r_rem[k] <= n_rem[k];
                r_n[k]   <= n_n[k];
            end
            for (int j = 0; j <= DW; j++) begin
                r_dc[j] <= n_dc[j];
                r_dr[j] <= n_dr[j];
                r_qa[j] <= n_qa[j];
                r_qb[j] <= n_qb[j];
            end
            for (int j = 0; j < DW; j++) begin
                r_ra[j] <= n_ra[j];
                r_rb[j] <= n_rb[j];
            end
            r_moff  <= r_dc[DW].off;
            r_mzs   <= r_dc[DW].zs;
            r_mneg  <= r_dc[DW].neg;
            r_mroot <= r_dr[DW];
            for (int p = 0; p < 6; p++) r_mp[p] <= n_mp[p];
            r_mqa   <= n_mqa;
            r_mqb   <= n_mqb;
            r_osp   <= n_osp;
            r_oclip <= n_oclip;
        end
    end

    assign o_valid  = r_ov;
    assign o_spinor = r_osp;
    assign o_clip   = r_oclip;

endmodule

`default_nettype wire

>>> sv/spinor_bracket_product.sv
// ----------------------------------------------------------------------------
// spinor_bracket_product
// Complex antisymmetric bracket product of two four-momenta, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel i_in takes one momentum pair with its off-shell flags and
// the bracket mode per transfer; output channel o_out returns one product
// (real, imaginary, saturated flag) per transfer, in order.
// Throughput: one pair per cycle while o_out is not stalled.
// The pipeline depth is set by the square root and the dividers, which
// resolve one bit per pipeline stage, followed by two multiply stages
// and three add or saturate stages.
// Config writes on i_cfg_we load eta_first (index 0) or eta_second
// (index 1); write them only while the pipeline is empty.
// Reset clears every stage valid and sets both eta registers to 1.0.
// When o_out stalls, the whole pipeline holds and i_in.ready drops in the
// same cycle; no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spinor_bracket_product_defines.svh"

module spinor_bracket_product #(
    parameter int FRAC_BITS = sbp_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sbp_pkg::DATA_W-1:0]    i_cfg_data,
    sbp_in_if.sink                        i_in,
    sbp_out_if.source                     o_out
);
    import sbp_pkg::*;

    localparam int MW = 2 * DATA_W;
    localparam int YW = MW + 1;
    localparam int ZW = MW + 2;
    localparam logic [DATA_W-1:0] ETA_ONE = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [OUT_W-1:0] POS_RAIL = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_RAIL = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [ZW-1:0] Z_MAX = ZW'(POS_RAIL);
    localparam logic signed [ZW-1:0] Z_MIN = ZW'($signed(NEG_RAIL));

    function automatic logic [OUT_W:0] f_sat(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] v;
        v = a >>> FRAC_BITS;
        if (v > Z_MAX) return {1'b1, POS_RAIL};
        if (v < Z_MIN) return {1'b1, NEG_RAIL};
        return {1'b0, v[OUT_W-1:0]};
    endfunction

    logic [DATA_W-1:0]    r_eta_first;
    logic [DATA_W-1:0]    r_eta_second;
    logic                 w_en;
    t_spin_ctl            w_ctl;
    t_momentum            w_mom_a;
    t_momentum            w_mom_b;
    t_eta                 w_eta;
    logic                 w_spa_valid;
    logic                 w_spb_valid;
    t_spinor              w_spa;
    t_spinor              w_spb;
    logic                 w_spa_clip;
    logic                 w_spb_clip;

    logic                 r_xv;
    logic signed [MW-1:0] r_xp [8];
    logic                 r_xclip;
    logic signed [MW-1:0] n_xp [8];
    logic                 r_yv;
    logic signed [YW-1:0] r_ys [4];
    logic                 r_yclip;
    logic signed [YW-1:0] n_ys [4];
    logic                 r_zv;
    logic [OUT_W-1:0]     r_zre;
    logic [OUT_W-1:0]     r_zim;
    logic                 r_zsat;
    logic [OUT_W:0]       w_re;
    logic [OUT_W:0]       w_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_first  <= ETA_ONE;
            r_eta_second <= ETA_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ETA_FIRST:  r_eta_first  <= i_cfg_data;
                REG_ETA_SECOND: r_eta_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_zv || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        w_ctl.en            = w_en;
        w_ctl.valid         = i_in.valid;
        w_ctl.conj          = i_in.data.mode;
        w_mom_a.energy      = i_in.data.first_energy;
        w_mom_a.px          = i_in.data.first_px;
        w_mom_a.py          = i_in.data.first_py;
        w_mom_a.pz          = i_in.data.first_pz;
        w_mom_a.off_shell   = i_in.data.first_off_shell;
        w_mom_b.energy      = i_in.data.second_energy;
        w_mom_b.px          = i_in.data.second_px;
        w_mom_b.py          = i_in.data.second_py;
        w_mom_b.pz          = i_in.data.second_pz;
        w_mom_b.off_shell   = i_in.data.second_off_shell;
        w_eta.eta_first     = $signed(r_eta_first);
        w_eta.eta_second    = $signed(r_eta_second);
    end

    sbp_spinor #(.FRAC_BITS(FRAC_BITS)) u_spinor_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_mom    (w_mom_a),
        .i_eta    (w_eta),
        .o_valid  (w_spa_valid),
        .o_spinor (w_spa),
        .o_clip   (w_spa_clip)
    );

    sbp_spinor #(.FRAC_BITS(FRAC_BITS)) u_spinor_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_mom    (w_mom_b),
        .i_eta    (w_eta),
        .o_valid  (w_spb_valid),
        .o_spinor (w_spb),
        .o_clip   (w_spb_clip)
    );

    always_comb begin
        n_xp[0] = MW'(w_spa.l0_re) * MW'(w_spb.l1_re);
        n_xp[1] = MW'(w_spa.l0_im) * MW'(w_spb.l1_im);
        n_xp[2] = MW'(w_spa.l1_re) * MW'(w_spb.l0_re);
        n_xp[3] = MW'(w_spa.l1_im) * MW'(w_spb.l0_im);
        n_xp[4] = MW'(w_spa.l0_re) * MW'(w_spb.l1_im);
        n_xp[5] = MW'(w_spa.l0_im) * MW'(w_spb.l1_re);
        n_xp[6] = MW'(w_spa.l1_re) * MW'(w_spb.l0_im);
        n_xp[7] = MW'(w_spa.l1_im) * MW'(w_spb.l0_re);
    end

    always_comb begin
        n_ys[0] = YW'(r_xp[0]) - YW'(r_xp[1]);
        n_ys[1] = YW'(r_xp[3]) - YW'(r_xp[2]);
        n_ys[2] = YW'(r_xp[4]) + YW'(r_xp[5]);
        n_ys[3] = YW'(r_xp[6]) + YW'(r_xp[7]);
    end

    always_comb begin
        w_re = f_sat(ZW'(r_ys[0]) + ZW'(r_ys[1]));
        w_im = f_sat(ZW'(r_ys[2]) - ZW'(r_ys[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
            r_yv <= 1'b0;
            r_zv <= 1'b0;
        end else if (w_en) begin
            r_xv <= w_spa_valid & w_spb_valid;
            r_yv <= r_xv;
            r_zv <= r_yv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int p = 0; p < 8; p++) r_xp[p] <= n_xp[p];
            r_xclip <= w_spa_clip | w_spb_clip;
            for (int p = 0; p < 4; p++) r_ys[p] <= n_ys[p];
            r_yclip <= r_xclip;
            r_zre   <= w_re[OUT_W-1:0];
            r_zim   <= w_im[OUT_W-1:0];
            r_zsat  <= r_yclip | w_re[OUT_W] | w_im[OUT_W];
        end
    end

    assign o_out.valid           = r_zv;
    assign o_out.data.product_re = $signed(r_zre);
    assign o_out.data.product_im = $signed(r_zim);
    assign o_out.data.saturated  = r_zsat;

    `SBP_ASSERT(a_lanes_aligned, w_spa_valid == w_spb_valid, "spinor lanes out of step")
    `SBP_ASSERT(a_stall_blocks_input, r_zv && !o_out.ready |-> !i_in.ready, "input taken during stall")
    `SBP_ASSERT(a_lane_advance, w_en && w_spa_valid |=> r_xv, "spinor result dropped")
    `SBP_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out.valid, "output valid after reset")

endmodule

`default_nettype wire
